[rtl/core/xlte_pkg.sv]
// Shared constants, types and helpers for the length-tagged XXTEA encryptor.
`timescale 1ns / 1ps
package xlte_pkg;

  localparam int          WORD_W          = 32;
  localparam int          VB_W            = 3;
  localparam int          KEY_IDX_W       = 2;
  localparam int          KEY_WORDS       = 4;
  localparam int          N_W             = 7;
  localparam int          ROUND_W         = 6;
  localparam int          STORE_WORDS_DEF = 64;
  localparam logic [31:0] XX_DELTA        = 32'h9E37_79B9;

  typedef logic [WORD_W-1:0] word_t;

  // Rounds for a run of n words: 6 + 52/n, for n from 2 to 64.
  function automatic logic [ROUND_W-1:0] round_count(input logic [N_W-1:0] n);
    logic [ROUND_W-1:0] extra;
    case (n) inside
      7'd2:             extra = 6'd26;
      7'd3:             extra = 6'd17;
      7'd4:             extra = 6'd13;
      7'd5:             extra = 6'd10;
      7'd6:             extra = 6'd8;
      7'd7:             extra = 6'd7;
      7'd8:             extra = 6'd6;
      [7'd9:7'd10]:     extra = 6'd5;
      [7'd11:7'd13]:    extra = 6'd4;
      [7'd14:7'd17]:    extra = 6'd3;
      [7'd18:7'd26]:    extra = 6'd2;
      [7'd27:7'd52]:    extra = 6'd1;
      default:          extra = 6'd0;
    endcase
    return extra + 6'd6;
  endfunction

  // Keep the low valid_bytes bytes of a word.
  function automatic word_t byte_mask(input logic [VB_W-1:0] vb);
    word_t m;
    case (vb)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

[rtl/core/xlte_in_if.sv]
// Input channel: message words with byte count and end-of-message flag.
`timescale 1ns / 1ps
interface xlte_in_if;
  logic                           valid;
  logic                           ready;
  logic [xlte_pkg::WORD_W-1:0]    data_word;
  logic [xlte_pkg::VB_W-1:0]      valid_bytes;
  logic                           last;

  modport source (output valid, output data_word, output valid_bytes, output last,
                  input ready);
  modport sink   (input valid, input data_word, input valid_bytes, input last,
                  output ready);
endinterface

[rtl/core/xlte_out_if.sv]
// Result channel: ciphertext words with end-of-run and overflow flags.
`timescale 1ns / 1ps
interface xlte_out_if;
  logic                           valid;
  logic                           ready;
  logic [xlte_pkg::WORD_W-1:0]    cipher_word;
  logic                           last_res;
  logic                           overflow;

  modport source (output valid, output cipher_word, output last_res, output overflow,
                  input ready);
  modport sink   (input valid, input cipher_word, input last_res, input overflow,
                  output ready);
endinterface

[rtl/core/xxtea_length_tagged_encrypt_core.sv]
// Top level of the length-tagged XXTEA encryptor.
//
// Usage: write the 128-bit key through cfg_we/cfg_index/cfg_wdata (four 32-bit
// words, index 0 holds key bytes 0-3) while the core is idle. Then send the
// message on in_ch, one little-endian word per transfer; valid_bytes counts the
// bytes of the word marked last, earlier words always carry four bytes.
// Loading accepts one word per cycle. Up to STORE_WORDS-1 words are kept; extra
// words are dropped and every result word of that run has overflow set.
// After the last word the core appends the byte length as one more word
// (n words in total) and encrypts the store in place. in_ch.ready stays low
// from the last transfer until the final result word is taken.
// After the last input transfer the core runs 6 + 52/n rounds over the store;
// each word of each round passes S_CALC1, which forms the mixing terms, then
// S_CALC2, which adds them in and writes the word back. The n result words then
// leave at one per cycle; a stall on out_ch holds the current word and its flags.
// A last word with no bytes on an empty store yields no result.
// Reset (rst_n low, synchronous) clears the key, the word count and the
// overflow flag; the store contents are left as they were.
`timescale 1ns / 1ps
module xxtea_length_tagged_encrypt_core #(
  parameter int STORE_WORDS = xlte_pkg::STORE_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [xlte_pkg::KEY_IDX_W-1:0]    cfg_index,
  input  logic [xlte_pkg::WORD_W-1:0]       cfg_wdata,
  xlte_in_if.sink                           in_ch,
  xlte_out_if.source                        out_ch
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam int CW = $clog2(STORE_WORDS + 1);
  localparam int NW = xlte_pkg::N_W;
  localparam int RW = xlte_pkg::ROUND_W;
  localparam logic [AW-1:0] CAP = AW'(STORE_WORDS - 1);

  typedef enum logic [4:0] {
    S_LOAD   = 5'b00001,
    S_APPEND = 5'b00010,
    S_CALC1  = 5'b00100,
    S_CALC2  = 5'b01000,
    S_SEND   = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          count_r, count_nxt;
  logic                   ovf_r, ovf_nxt;
  xlte_pkg::word_t        len_r, len_nxt;
  logic [AW-1:0]          lastidx_r, lastidx_nxt;
  logic [AW-1:0]          p_r, p_nxt;
  logic [RW-1:0]          rounds_r, rounds_nxt;
  xlte_pkg::word_t        sum_r, sum_nxt;
  xlte_pkg::word_t        prev_r, prev_nxt;
  xlte_pkg::word_t        s_r, s_nxt;
  xlte_pkg::word_t        k_r, k_nxt;
  xlte_pkg::word_t        key_r [xlte_pkg::KEY_WORDS];

  logic                   st_we;
  logic [AW-1:0]          st_waddr;
  xlte_pkg::word_t        st_wdata;
  logic                   st_re_a, st_re_b;
  logic [AW-1:0]          st_raddr_a, st_raddr_b;
  xlte_pkg::word_t        x_w, y_w;

  logic                   in_xfer;
  logic [xlte_pkg::VB_W-1:0] vb_c;
  xlte_pkg::word_t        len_c;
  logic [CW-1:0]          n_c;
  logic [1:0]             key_sel;
  xlte_pkg::word_t        mix_w;
  logic [AW-1:0]          p_inc;

  xlte_store #(
    .STORE_WORDS (STORE_WORDS),
    .AW          (AW)
  ) u_store (
    .clk     (clk),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .re_a    (st_re_a),
    .raddr_a (st_raddr_a),
    .rdata_a (x_w),
    .re_b    (st_re_b),
    .raddr_b (st_raddr_b),
    .rdata_b (y_w)
  );

  assign in_ch.ready        = (state_r == S_LOAD);
  assign in_xfer            = in_ch.valid && (state_r == S_LOAD);
  assign out_ch.valid       = (state_r == S_SEND);
  assign out_ch.cipher_word = x_w;
  assign out_ch.last_res    = (p_r == lastidx_r);
  assign out_ch.overflow    = ovf_r;

  assign vb_c    = (in_ch.valid_bytes > 3'd4) ? 3'd4 : in_ch.valid_bytes;
  assign len_c   = 32'({count_r, 2'b00}) + 32'(vb_c);
  assign n_c     = CW'(count_r) + CW'(1);
  assign key_sel = 2'(p_r) ^ sum_r[3:2];
  assign mix_w   = x_w + s_r + k_r;
  assign p_inc   = p_r + AW'(1);

  // Key registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < xlte_pkg::KEY_WORDS; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    len_nxt     = len_r;
    lastidx_nxt = lastidx_r;
    p_nxt       = p_r;
    rounds_nxt  = rounds_r;
    sum_nxt     = sum_r;
    prev_nxt    = prev_r;
    s_nxt       = s_r;
    k_nxt       = k_r;
    st_we       = 1'b0;
    st_waddr    = count_r;
    st_wdata    = in_ch.data_word;
    st_re_a     = 1'b0;
    st_re_b     = 1'b0;
    st_raddr_a  = '0;
    st_raddr_b  = AW'(1);

    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (count_r < CAP) begin
            if (!in_ch.last) begin
              st_we     = 1'b1;
              count_nxt = count_r + AW'(1);
            end else if (len_c == '0) begin
              // Empty message: drop the run.
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end else begin
              st_we     = 1'b1;
              st_wdata  = in_ch.data_word & xlte_pkg::byte_mask(vb_c);
              count_nxt = count_r + AW'(1);
              len_nxt   = len_c;
              state_nxt = S_APPEND;
            end
          end else begin
            ovf_nxt = 1'b1;
            if (in_ch.last) begin
              len_nxt   = 32'({count_r, 2'b00});
              state_nxt = S_APPEND;
            end
          end
        end
      end

      S_APPEND: begin
        st_we       = 1'b1;
        st_wdata    = len_r;
        lastidx_nxt = count_r;
        prev_nxt    = len_r;
        sum_nxt     = xlte_pkg::XX_DELTA;
        p_nxt       = '0;
        rounds_nxt  = xlte_pkg::round_count(NW'(n_c));
        st_re_a     = 1'b1;
        st_re_b     = 1'b1;
        state_nxt   = S_CALC1;
      end

      S_CALC1: begin
        s_nxt     = (((prev_r >> 5) ^ (y_w << 2))) +
                    (((y_w >> 3) ^ (prev_r << 4)) ^ (sum_r ^ y_w));
        k_nxt     = key_r[key_sel] ^ prev_r;
        state_nxt = S_CALC2;
      end

      S_CALC2: begin
        st_we    = 1'b1;
        st_waddr = p_r;
        st_wdata = mix_w;
        prev_nxt = mix_w;
        st_re_a  = 1'b1;
        st_re_b  = 1'b1;
        if (p_r == lastidx_r) begin
          p_nxt      = '0;
          st_raddr_a = '0;
          st_raddr_b = (lastidx_r == '0) ? '0 : AW'(1);
          if (rounds_r == RW'(1)) begin
            rounds_nxt = '0;
            state_nxt  = S_SEND;
          end else begin
            rounds_nxt = rounds_r - RW'(1);
            sum_nxt    = sum_r + xlte_pkg::XX_DELTA;
            state_nxt  = S_CALC1;
          end
        end else begin
          p_nxt      = p_inc;
          st_raddr_a = p_inc;
          st_raddr_b = (p_inc == lastidx_r) ? '0 : p_inc + AW'(1);
          state_nxt  = S_CALC1;
        end
      end

      S_SEND: begin
        if (out_ch.ready) begin
          if (p_r == lastidx_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            // Advance to the next word; the read lands as this transfer completes.
            p_nxt      = p_inc;
            st_re_a    = 1'b1;
            st_raddr_a = p_inc;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      p_r       <= '0;
      lastidx_r <= '0;
      rounds_r  <= '0;
      sum_r     <= '0;
      prev_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ovf_r     <= ovf_nxt;
      p_r       <= p_nxt;
      lastidx_r <= lastidx_nxt;
      rounds_r  <= rounds_nxt;
      sum_r     <= sum_nxt;
      prev_r    <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    s_r   <= s_nxt;
    k_r   <= k_nxt;
  end

endmodule

[rtl/core/xlte_store.sv]
// Word store: one write port, two registered read ports with write bypass.
`timescale 1ns / 1ps
module xlte_store #(
  parameter int STORE_WORDS = xlte_pkg::STORE_WORDS_DEF,
  parameter int AW          = $clog2(STORE_WORDS)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  xlte_pkg::word_t       wdata,
  input  logic                  re_a,
  input  logic [AW-1:0]         raddr_a,
  output xlte_pkg::word_t       rdata_a,
  input  logic                  re_b,
  input  logic [AW-1:0]         raddr_b,
  output xlte_pkg::word_t       rdata_b
);

  xlte_pkg::word_t mem [STORE_WORDS];
  xlte_pkg::word_t rdata_a_r;
  xlte_pkg::word_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Reads that hit the word being written take the new value.
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a_r <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
    end
    if (re_b) begin
      rdata_b_r <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

[tb/sv/tb_xxtea_length_tagged_encrypt_core.sv]
// Self-checking testbench for the length-tagged XXTEA encryptor core.
`timescale 1ns / 1ps
module tb_xxtea_length_tagged_encrypt_core;

  localparam int          STORE_DEPTH   = 64;
  localparam logic [31:0] TEA_DELTA     = 32'h9E37_79B9;
  localparam int          SETTLE_CYCLES = 800;
  localparam int          HOLD_CYCLES   = 1500;
  localparam int          CYCLE_LIMIT   = 400_000;

  localparam logic [xlte_pkg::KEY_IDX_W-1:0] REG_KEY_WORD_0 = 2'd0;
  localparam logic [xlte_pkg::KEY_IDX_W-1:0] REG_KEY_WORD_1 = 2'd1;
  localparam logic [xlte_pkg::KEY_IDX_W-1:0] REG_KEY_WORD_2 = 2'd2;
  localparam logic [xlte_pkg::KEY_IDX_W-1:0] REG_KEY_WORD_3 = 2'd3;

  typedef logic [xlte_pkg::WORD_W-1:0] word_t;

  typedef struct packed {
    word_t word;
    logic  fin;
    logic  ovf;
  } cipher_word_t;

  // n_words: result words the message ending on this row yields, -1 where not a last word
  typedef struct packed {
    word_t                   data;
    logic [xlte_pkg::VB_W-1:0] vb;
    logic                    lst;
    int                      n_words;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [xlte_pkg::KEY_IDX_W-1:0] cfg_index;
  word_t cfg_wdata;

  xlte_in_if  in_ch();
  xlte_out_if out_ch();

  xxtea_length_tagged_encrypt_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state
  word_t        key_q [4];
  word_t        msg_store [STORE_DEPTH];
  int unsigned  fill;
  logic         dropped;
  cipher_word_t cipher_q [$];

  int unsigned err_count;
  int unsigned cycle_no;
  int unsigned words_taken;
  int unsigned runs_taken;
  int unsigned words_checked;
  int unsigned ovf_runs;
  int unsigned empty_runs;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        stall_req;
  int unsigned stall_left;

  dir_row_t dir_rows [13] = '{
    '{32'h0000_0000, 3'd0, 1'b1,  0},   // empty message
    '{32'hFFFF_FFFF, 3'd1, 1'b1,  2},
    '{32'h0000_0000, 3'd4, 1'b1,  2},
    '{32'hAAAA_AAAA, 3'd0, 1'b0, -1},   // count ignored on a non-last word
    '{32'hFFFF_FFFF, 3'd0, 1'b1,  3},   // last word carries no bytes
    '{32'h1234_5678, 3'd7, 1'b1,  2},   // count above four clamps
    '{32'h8000_0000, 3'd5, 1'b1,  2},
    '{32'h5555_5555, 3'd7, 1'b0, -1},
    '{32'h0000_FFFF, 3'd6, 1'b0, -1},
    '{32'hDEAD_BEEF, 3'd2, 1'b1,  4},
    '{32'h0102_0304, 3'd3, 1'b1,  2},
    '{32'hFFFF_FFFF, 3'd4, 1'b0, -1},
    '{32'hFFFF_FFFF, 3'd4, 1'b1,  3}
  };

  // Block XXTEA over the first n store words, in place
  function automatic void encipher_store(input int unsigned n);
    word_t       sum, y, z, mx;
    int unsigned rounds, e;
    rounds = 6 + 52 / n;
    sum    = '0;
    z      = msg_store[n-1];
    repeat (rounds) begin
      sum += TEA_DELTA;
      e = (sum >> 2) & 3;
      for (int unsigned p = 0; p < n; p++) begin
        y  = msg_store[(p + 1 == n) ? 0 : p + 1];
        mx = ((z >> 5) ^ (y << 2)) + (((y >> 3) ^ (z << 4)) ^ (sum ^ y))
             + (key_q[((p & 3) ^ e) & 3] ^ z);
        msg_store[p] += mx;
        z = msg_store[p];
      end
    end
  endfunction

  // Load one accepted word; on the last word append the length and queue the cipher words
  function automatic void absorb_word(input word_t data, input logic [2:0] vb,
                                      input logic lst);
    word_t        len, mask;
    int unsigned  nb, n;
    cipher_word_t cw;
    if (!lst) begin
      if (fill < STORE_DEPTH - 1) begin
        msg_store[fill] = data;
        fill++;
      end else begin
        dropped = 1'b1;
      end
      return;
    end
    nb = (vb > 4) ? 4 : vb;
    if (fill < STORE_DEPTH - 1) begin
      len = 4 * fill + nb;
      if (len == 0) begin
        empty_runs++;
        fill    = 0;
        dropped = 1'b0;
        return;
      end
      mask = (nb == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nb)) - 32'd1);
      msg_store[fill] = data & mask;
      fill++;
    end else begin
      dropped = 1'b1;
      len     = 4 * fill;
    end
    msg_store[fill] = len;
    n = fill + 1;
    encipher_store(n);
    for (int unsigned i = 0; i < n; i++) begin
      cw.word = msg_store[i];
      cw.fin  = (i == n - 1);
      cw.ovf  = dropped;
      cipher_q = {cipher_q, cw};
    end
    if (dropped) ovf_runs++;
    fill    = 0;
    dropped = 1'b0;
  endfunction

  always @(posedge clk) begin : watch_ports
    cipher_word_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        words_taken++;
        if (in_ch.last) runs_taken++;
        absorb_word(in_ch.data_word, in_ch.valid_bytes, in_ch.last);
      end
      if (out_ch.valid && out_ch.ready) begin
        words_checked++;
        if (cipher_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected transfer, expected none, got word %h last %b ovf %b",
                   $time, out_ch.cipher_word, out_ch.last_res, out_ch.overflow);
        end else begin
          want = cipher_q.pop_front();
          if (out_ch.cipher_word !== want.word) begin
            err_count++;
            $display("%0t: cipher_word mismatch, expected %h, got %h",
                     $time, want.word, out_ch.cipher_word);
          end
          if (out_ch.last_res !== want.fin) begin
            err_count++;
            $display("%0t: last_res mismatch, expected %b, got %b",
                     $time, want.fin, out_ch.last_res);
          end
          if (out_ch.overflow !== want.ovf) begin
            err_count++;
            $display("%0t: overflow mismatch, expected %b, got %b",
                     $time, want.ovf, out_ch.overflow);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_no++;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d cipher words outstanding", $time, cipher_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_left = HOLD_CYCLES;
        stall_req  = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer, valid still high
  task automatic push_word(input word_t data, input logic [2:0] vb, input logic lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_word   <= data;
    in_ch.valid_bytes <= vb;
    in_ch.last        <= lst;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_message(input int words, input logic [2:0] last_vb);
    word_t       data;
    logic [2:0]  vb;
    for (int i = 0; i < words; i++) begin
      case ($urandom_range(0, 15))
        0:       data = 32'h0000_0000;
        1:       data = 32'hFFFF_FFFF;
        default: data = $urandom;
      endcase
      // mostly four bytes on body words, sometimes a stray count
      vb = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      if (i == words - 1) push_word(data, last_vb, 1'b1);
      else                push_word(data, vb, 1'b0);
    end
  endtask

  task automatic send_random_message();
    int         words;
    logic [2:0] vb;
    words = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 5);
    vb    = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    send_message(words, vb);
  endtask

  // Hold the sender until every predicted word has been taken
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (cipher_q.size() != 0);
  endtask

  task automatic write_key(input logic [xlte_pkg::KEY_IDX_W-1:0] idx, input word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    key_q[idx] = val;
    @(negedge clk);
  endtask

  task automatic set_keys(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
    drain_results();
    // an empty message may still be in flight with nothing predicted
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_key(REG_KEY_WORD_0, k0);
    write_key(REG_KEY_WORD_1, k1);
    write_key(REG_KEY_WORD_2, k2);
    write_key(REG_KEY_WORD_3, k3);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned msg_base;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_KEY_WORD_0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.data_word   = '0;
    in_ch.valid_bytes = '0;
    in_ch.last        = 1'b0;
    stall_req         = 1'b0;
    send_idle_pct     = 12;
    recv_idle_pct     = 86;
    fill              = 0;
    dropped           = 1'b0;
    err_count         = 0;
    cycle_no          = 0;
    words_taken       = 0;
    runs_taken        = 0;
    words_checked     = 0;
    ovf_runs          = 0;
    empty_runs        = 0;
    for (int i = 0; i < 4; i++) key_q[i] = '0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows under the reset key
    msg_base = words_checked;
    foreach (dir_rows[r]) begin
      push_word(dir_rows[r].data, dir_rows[r].vb, dir_rows[r].lst);
      if (dir_rows[r].lst) begin
        drain_results();
        if (words_checked - msg_base != dir_rows[r].n_words) begin
          err_count++;
          $display("%0t: row %0d word count mismatch, expected %0d, got %0d",
                   $time, r, dir_rows[r].n_words, words_checked - msg_base);
        end
        msg_base = words_checked;
      end
    end

    // All-ones key; long output hold fills the core while the sender keeps offering
    set_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    stall_req = 1'b1;
    send_message(10, 3'd4);
    send_message(63, 3'($urandom_range(1, 4)));   // exactly fills the store
    while (words_taken < 110) send_random_message();

    // Random key, sender mostly idle
    set_keys($urandom, $urandom, $urandom, $urandom);
    send_idle_pct = 86;
    recv_idle_pct = 12;
    send_message(64, 3'($urandom_range(1, 4)));   // last word dropped
    while (words_taken < 190) send_random_message();

    // Mixed key, no idling on either side
    set_keys(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_message(67, 3'($urandom_range(1, 4)));   // several words dropped
    drain_results();
    while (words_taken < 280) send_random_message();

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d input words in %0d messages, %0d cipher words checked,",
             words_taken, runs_taken, words_checked);
    $display("%0d runs with dropped words, %0d empty, four key settings, three idle mixes.",
             ovf_runs, empty_runs);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
